[design/b64d_pkg.sv]
package b64d_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;

   localparam logic [7:0] OFFSET_LOWER = 8'd26;
   localparam logic [7:0] OFFSET_DIGIT = 8'd52;
   localparam logic [5:0] SEXTET_PLUS  = 6'd62;
   localparam logic [5:0] SEXTET_SLASH = 6'd63;

   typedef struct packed {
      logic       invalid;
      logic [5:0] value;
   } sextet_type;

   typedef struct packed {
      logic [23:0] chunk;
      logic [1:0]  last_index;
      logic        eot;
      logic        err;
   } job_type;

   function automatic sextet_type sextet_of(input logic [7:0] ch);
      sextet_type s;
      logic [7:0] t;
      s = '{invalid: 1'b0, value: 6'd0};
      t = 8'd0;
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
         t = ch - CHAR_UPPER_A;
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
         t = ch - CHAR_LOWER_A + OFFSET_LOWER;
      end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
         t = ch - CHAR_DIGIT_0 + OFFSET_DIGIT;
      end else if (ch == CHAR_PLUS) begin
         t = {2'b00, SEXTET_PLUS};
      end else if (ch == CHAR_SLASH) begin
         t = {2'b00, SEXTET_SLASH};
      end else begin
         s.invalid = 1'b1;
      end
      s.value = t[5:0];
      return s;
   endfunction

endpackage

[design/base64_strict_stream_decoder.sv]
// Strict base64 decoder, one text character per request.
// Request channel: req_valid / req_stall with req_char_code and req_text_end;
// req_text_end marks the last character of a text. A request is taken at a
// clock edge with req_valid high and req_stall low.
// Response channel: rsp_valid / rsp_stall with one decoded byte or status
// per response. Every fourth character yields up to three byte responses;
// the last character of a text yields an end_of_text response that carries
// decode_error. rsp_last_of_run marks the last response of a request.
// Throughput: one request per cycle while req_stall is low, one response
// per cycle while rsp_stall is low. The response port is the limit: a
// request that closes a group issues up to three responses.
// A queue of QUEUE_DEPTH groups sits between the character front end and
// the response stage; req_stall rises only when that queue is full, so a
// stalled receiver holds back requests only once the queue fills.
// Reset (synchronous, active high) clears the group state, the error flag,
// the queue, and the response valid flag; no response is valid after reset.
module base64_strict_stream_decoder #(
   parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_text_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_decode_error,
   output logic       rsp_end_of_text,
   output logic       rsp_last_of_run
);

   logic              accept;
   logic              push;
   b64d_pkg::job_type push_job;
   logic              pop;
   logic              full;
   logic              not_empty;
   b64d_pkg::job_type head_job;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   b64d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_char_code),
      .text_end  (req_text_end),
      .push      (push),
      .push_job  (push_job)
   );

   b64d_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head_job  (head_job)
   );

   b64d_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (not_empty),
      .job              (head_job),
      .pop              (pop),
      .out_stall        (rsp_stall),
      .out_valid        (rsp_valid),
      .out_data_byte    (rsp_data_byte),
      .out_byte_valid   (rsp_byte_valid),
      .out_decode_error (rsp_decode_error),
      .out_end_of_text  (rsp_end_of_text),
      .out_last_of_run  (rsp_last_of_run)
   );

endmodule

[design/b64d_front.sv]
module b64d_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        char_code,
   input  logic              text_end,
   output logic              push,
   output b64d_pkg::job_type push_job
);

   logic [1:0]  pos_ff, pos_in;
   logic [17:0] acc_ff, acc_in;
   logic [1:0]  pad_ff, pad_in;
   logic        error_ff, error_in;

   b64d_pkg::sextet_type sx;
   logic        is_pad;
   logic [1:0]  pad_inc;
   logic [5:0]  v;
   logic        ended;

   always_comb begin
      sx       = b64d_pkg::sextet_of(char_code);
      is_pad   = (char_code == b64d_pkg::CHAR_PAD);
      pad_inc  = pad_ff;
      v        = 6'd0;
      ended    = 1'b0;
      error_in = error_ff;
      pos_in   = pos_ff;
      acc_in   = acc_ff;
      pad_in   = pad_ff;
      if (!error_ff) begin
         if (is_pad) begin
            if (pos_ff < 2'd2) begin
               error_in = 1'b1;
            end else begin
               pad_inc = pad_ff + 2'd1;
            end
         end else if (pad_ff != 2'd0 || sx.invalid) begin
            error_in = 1'b1;
         end else begin
            v = sx.value;
         end
         if (!error_in) begin
            if (pos_ff == 2'd3) begin
               if (pad_inc != 2'd0 && !text_end) begin
                  error_in = 1'b1;
               end else begin
                  ended = 1'b1;
               end
               pos_in = 2'd0;
               acc_in = 18'd0;
               pad_in = 2'd0;
            end else begin
               acc_in = {acc_ff[11:0], v};
               pos_in = pos_ff + 2'd1;
               pad_in = pad_inc;
            end
         end
      end
      if (text_end) begin
         error_in = 1'b0;
         pos_in   = 2'd0;
         acc_in   = 18'd0;
         pad_in   = 2'd0;
      end
   end

   always_comb begin
      push_job.chunk = {acc_ff, v};
      case (pad_inc)
         2'd0:    push_job.last_index = 2'd2;
         2'd1:    push_job.last_index = 2'd1;
         default: push_job.last_index = 2'd0;
      endcase
      push_job.eot = text_end;
      push_job.err = text_end && !ended;
      if (push_job.err) begin
         push_job.last_index = 2'd0;
      end
      push = accept && (ended || text_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 2'd0;
         acc_ff   <= 18'd0;
         pad_ff   <= 2'd0;
         error_ff <= 1'b0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         acc_ff   <= acc_in;
         pad_ff   <= pad_in;
         error_ff <= error_in;
      end
   end

endmodule

[design/b64d_queue.sv]
module b64d_queue #(
   parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64d_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output b64d_pkg::job_type head_job
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   b64d_pkg::job_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == DEPTH_CNT);
      not_empty = (count_ff != '0);
      head_job  = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[design/b64d_back.sv]
module b64d_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  b64d_pkg::job_type job,
   output logic              pop,
   input  logic              out_stall,
   output logic              out_valid,
   output logic [7:0]        out_data_byte,
   output logic              out_byte_valid,
   output logic              out_decode_error,
   output logic              out_end_of_text,
   output logic              out_last_of_run
);

   logic [1:0] index_ff, index_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       bvalid_ff, bvalid_in;
   logic       err_ff, err_in;
   logic       eot_ff, eot_in;
   logic       last_ff, last_in;
   logic       load;
   logic       is_last;

   always_comb begin
      load     = job_valid && (!valid_ff || !out_stall);
      is_last  = (index_ff == job.last_index);
      pop      = load && is_last;
      index_in = index_ff;
      valid_in = valid_ff && out_stall;
      case (index_ff)
         2'd0:    data_in = job.chunk[23:16];
         2'd1:    data_in = job.chunk[15:8];
         default: data_in = job.chunk[7:0];
      endcase
      bvalid_in = !job.err;
      err_in    = job.err;
      eot_in    = job.eot && is_last;
      last_in   = is_last;
      if (job.err) begin
         data_in = 8'd0;
      end
      if (load) begin
         valid_in = 1'b1;
         index_in = is_last ? 2'd0 : index_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff   <= data_in;
         bvalid_ff <= bvalid_in;
         err_ff    <= err_in;
         eot_ff    <= eot_in;
         last_ff   <= last_in;
      end
   end

   assign out_valid        = valid_ff;
   assign out_data_byte    = data_ff;
   assign out_byte_valid   = bvalid_ff;
   assign out_decode_error = err_ff;
   assign out_end_of_text  = eot_ff;
   assign out_last_of_run  = last_ff;

endmodule
